>>> hw/rtl/vft_pkg.sv
// shared types and constants of the value frequency table
package vft_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 31;
  localparam int unsigned SlotW  = 8;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [1:0] {
    StFound = 2'd0,
    StAdded = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CtlIdle = 1'b0,
    CtlScan = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic start;
    logic scan_en;
    logic commit;
  } vft_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
  } vft_sts_t;

endpackage

>>> hw/rtl/value_frequency_table.sv
// top level of the value frequency table
// Find-or-insert frequency count table. An input transaction on sample_value_i
// (valid/ready) looks up the value among the occupied slots in slot order.
// On a hit the slot's count rises by one, saturating at 2^31-1 (status found).
// On a miss with room the value is appended at the next free slot with count
// one (status added). On a miss with the table full, status full, slot 0 and
// count 0 are returned and the table is unchanged.
// Exactly one result transaction per input transaction, on status_o,
// slot_index_o and new_count_o (valid/ready), held in an output register.
// Scan: the scan reads one slot per cycle through a single registered read
// port of the value and count memories, stopping at a hit or after the last
// occupied slot; on an empty table a miss is found without reading a slot.
// One item is worked on at a time; the next is accepted the cycle after a
// result is loaded.
// Reset clears the fill level and the scan and valid state; the memories need no clearing.
// A stalled receiver holds the result register; a finished scan then waits
// until the result register is freed.
module value_frequency_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [vft_pkg::ValueW-1:0] sample_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [vft_pkg::SlotW-1:0]         slot_index_o,
  output logic [vft_pkg::CountW-1:0]        new_count_o
);
  import vft_pkg::*;

  vft_cmd_t cmd;
  vft_sts_t sts;

  vft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vft_dp #(
    .TableDepth (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_value_i (sample_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .new_count_o    (new_count_o)
  );

endmodule

>>> hw/rtl/vft_ctrl.sv
// controller state machine of the value frequency table
module vft_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  vft_pkg::vft_sts_t sts_i,
  output vft_pkg::vft_cmd_t cmd_o
);
  import vft_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_busy;
  logic       done;

  assign out_busy = out_valid_q && !out_ready_i;
  assign done     = sts_i.hit || sts_i.miss;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CtlIdle: begin
        if (in_valid_i) begin
          state_d = CtlScan;
        end
      end
      CtlScan: begin
        if (done && !out_busy) begin
          state_d = CtlIdle;
        end
      end
      default: state_d = CtlIdle;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.start   = 1'b0;
    cmd_o.scan_en = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      CtlIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      CtlScan: begin
        cmd_o.scan_en = !done;
        cmd_o.commit  = done && !out_busy;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CtlIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/vft_dp.sv
// datapath of the value frequency table: tables, scan pipeline, result register
module vft_dp #(
  parameter int unsigned TableDepth = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [vft_pkg::ValueW-1:0] sample_value_i,
  input  vft_pkg::vft_cmd_t                 cmd_i,
  output vft_pkg::vft_sts_t                 sts_o,
  output logic [1:0]                        status_o,
  output logic [vft_pkg::SlotW-1:0]         slot_index_o,
  output logic [vft_pkg::CountW-1:0]        new_count_o
);
  import vft_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned FillW = AddrW + 1;
  localparam logic [FillW-1:0] FillMax = FillW'(TableDepth);

  logic [ValueW-1:0] value_mem [TableDepth];
  logic [CountW-1:0] count_mem [TableDepth];

  logic [ValueW-1:0] key_q;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [FillW-1:0]  idx_q, idx_d;
  logic              rvld_q, rvld_d;
  logic [AddrW-1:0]  ridx_q;
  logic [ValueW-1:0] rval_q;
  logic [CountW-1:0] rcnt_q;
  logic [CountW-1:0] inc_cnt;
  logic              full;
  logic              last;
  logic              val_we, cnt_we;
  logic [AddrW-1:0]  wr_addr;
  logic [CountW-1:0] wr_cnt;

  assign full    = (fill_q == FillMax);
  assign last    = ({1'b0, ridx_q} == (fill_q - FillW'(1)));
  assign inc_cnt = (rcnt_q == CountMax) ? rcnt_q : rcnt_q + CountW'(1);

  assign sts_o.hit  = rvld_q && (rval_q == key_q);
  assign sts_o.miss = (fill_q == '0) || (rvld_q && (rval_q != key_q) && last);

  // commit write: increment on hit, append on miss with room
  always_comb begin
    val_we  = 1'b0;
    cnt_we  = 1'b0;
    wr_addr = fill_q[AddrW-1:0];
    wr_cnt  = CountW'(1);
    fill_d  = fill_q;
    if (cmd_i.commit) begin
      if (sts_o.hit) begin
        cnt_we  = 1'b1;
        wr_addr = ridx_q;
        wr_cnt  = inc_cnt;
      end else if (!full) begin
        val_we = 1'b1;
        cnt_we = 1'b1;
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  always_comb begin
    idx_d  = idx_q;
    rvld_d = rvld_q;
    if (cmd_i.start) begin
      idx_d  = '0;
      rvld_d = 1'b0;
    end else if (cmd_i.scan_en) begin
      idx_d  = idx_q + FillW'(1);
      rvld_d = (idx_q < fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      idx_q  <= idx_d;
      rvld_q <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      value_mem[wr_addr] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      count_mem[wr_addr] <= wr_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      rval_q <= value_mem[idx_q[AddrW-1:0]];
      rcnt_q <= count_mem[idx_q[AddrW-1:0]];
      ridx_q <= idx_q[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= sample_value_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (sts_o.hit) begin
        status_o     <= StFound;
        slot_index_o <= SlotW'(ridx_q);
        new_count_o  <= inc_cnt;
      end else if (full) begin
        status_o     <= StFull;
        slot_index_o <= '0;
        new_count_o  <= '0;
      end else begin
        status_o     <= StAdded;
        slot_index_o <= SlotW'(fill_q[AddrW-1:0]);
        new_count_o  <= CountW'(1);
      end
    end
  end

endmodule
